>>> hw/rtl/utf8_sanitizer_macros.svh
// Assertion macros for the UTF-8 sanitizer.
`ifndef UTF8_SANITIZER_MACROS_SVH
`define UTF8_SANITIZER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define UTF8S_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define UTF8S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8s_pkg.sv
// Types, constants and helper functions shared by the UTF-8 sanitizer.
`default_nettype none
package utf8s_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  localparam logic [2:0] LenBad   = 3'd0;
  localparam logic [2:0] LenAscii = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  localparam logic [1:0] PhaseFirst = 2'd0;
  localparam logic [1:0] PhaseMid   = 2'd1;
  localparam logic [1:0] PhaseLast  = 2'd2;

  // Output work for one input byte: replacements first, then literal bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lit;
    logic            last;
  } utf8s_cmd_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LenBad;
    if (b < ContCode) begin
      len = LenAscii;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      len = LenTwo;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      len = LenThree;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      len = LenFour;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/utf8_sanitizer.sv
// Top level of the streaming UTF-8 sanitizer with replacement character.
//
//   Channel   Dir  tdata           tlast          tuser
//   s_axis    in   [7:0] in_byte   payload_last   -
//   m_axis    out  [7:0] out_byte  payload_end    [0] run_last
//
// The input side takes one byte per cycle while the four-entry command queue has room.
// The output side sends one byte per cycle while m_axis_tready_i accepts, so a byte that
// yields n results occupies it for n transfers; a replaced byte yields three and a held byte none.
// Reset clears the open sequence, the queue and the output valid flag.
// A stall on the output fills the queue and then holds s_axis_tready_o low.
`default_nettype none
`include "utf8_sanitizer_macros.svh"
module utf8_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,
  output logic [0:0]      m_axis_tuser_o    // [0] run_last
);
  import utf8s_pkg::*;

  utf8s_cmd_t push_cmd, head_cmd;
  logic       q_push, q_full, q_pop, q_valid, seq_open;

  utf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd),
    .seq_open_o (seq_open)
  );

  utf8s_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_cmd)
  );

  utf8s_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_byte_o        (m_axis_tdata_o),
    .out_run_last_o    (m_axis_tuser_o[0]),
    .out_payload_end_o (m_axis_tlast_o)
  );

  `UTF8S_ASSERT_ALWAYS(a_end_is_run_last, !(m_axis_tvalid_o && m_axis_tlast_o) || m_axis_tuser_o[0], "payload end without run last")
  `UTF8S_ASSERT_ALWAYS(a_pop_needs_entry, !q_pop || q_valid, "pop from an empty command queue")
  `UTF8S_ASSERT_NEXT(a_last_closes_seq, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !seq_open, "sequence still open after payload end")

endmodule
`default_nettype wire

>>> hw/rtl/utf8s_fifo.sv
// Short command queue between the classifier and the output sequencer.
`default_nettype none
module utf8s_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire utf8s_pkg::utf8s_cmd_t data_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output utf8s_pkg::utf8s_cmd_t      data_o
);
  import utf8s_pkg::*;

  utf8s_cmd_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/utf8s_front.sv
// Input side: tracks the open sequence and turns each byte into an output command.
`default_nettype none
module utf8s_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  in_last_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output utf8s_pkg::utf8s_cmd_t      q_cmd_o,
  output logic                       seq_open_o
);
  import utf8s_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      exp_q, exp_d;
  utf8s_cmd_t      cmd;
  logic            accept;
  logic            is_cont;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cont    = ((in_byte_i & ContMask) == ContCode);
  assign seq_open_o = (cnt_q != 2'd0) && (exp_q > {1'b0, cnt_q});

  always_comb begin
    logic       fresh;
    logic [2:0] len;
    held_d   = held_q;
    cnt_d    = cnt_q;
    exp_d    = exp_q;
    cmd      = '0;
    cmd.last = in_last_i;
    fresh    = 1'b0;
    len      = lead_len(in_byte_i);
    if (seq_open_o) begin
      if (is_cont) begin
        if (({1'b0, cnt_q} + 3'd1) == exp_q) begin
          for (int k = 0; k < 4; k++) begin
            if (k < 3 && 2'(k) < cnt_q) begin
              cmd.lit[k] = held_q[k];
            end else if (2'(k) == cnt_q) begin
              cmd.lit[k] = in_byte_i;
            end
          end
          cmd.lit_cnt = {1'b0, cnt_q} + 3'd1;
          cnt_d       = 2'd0;
          exp_d       = 3'd0;
        end else if (cnt_q != 2'd3) begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) == cnt_q) begin
              held_d[k] = in_byte_i;
            end
          end
          cnt_d = cnt_q + 2'd1;
        end else begin
          cmd.rep_cnt = {1'b0, cnt_q} + 3'd1;
          cnt_d       = 2'd0;
          exp_d       = 3'd0;
        end
      end else begin
        cmd.rep_cnt = {1'b0, cnt_q};
        cnt_d       = 2'd0;
        exp_d       = 3'd0;
        fresh       = 1'b1;
      end
    end else begin
      cnt_d = 2'd0;
      exp_d = 3'd0;
      fresh = 1'b1;
    end
    if (fresh) begin
      if (len == LenAscii) begin
        cmd.lit[0]  = in_byte_i;
        cmd.lit_cnt = 3'd1;
      end else if (len == LenBad) begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end else begin
        held_d[0] = in_byte_i;
        cnt_d     = 2'd1;
        exp_d     = len;
      end
    end
    if (in_last_i && cnt_d != 2'd0) begin
      cmd.rep_cnt = cmd.rep_cnt + {1'b0, cnt_d};
      cnt_d       = 2'd0;
      exp_d       = 3'd0;
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept && (cmd.rep_cnt != 3'd0 || cmd.lit_cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= 2'd0;
      exp_q  <= 3'd0;
    end else if (accept) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      exp_q  <= exp_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/utf8s_back.sv
// Output side: plays out each queued command one byte per transfer.
`default_nettype none
module utf8s_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire utf8s_pkg::utf8s_cmd_t q_cmd_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_run_last_o,
  output logic                       out_payload_end_o
);
  import utf8s_pkg::*;

  logic [2:0] rep_idx_q, rep_idx_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] lit_idx_q, lit_idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       run_last_q, payload_end_q;
  logic       adv, in_rep, fin;
  logic [7:0] cur_byte;

  assign adv    = q_valid_i && (!valid_q || out_ready_i);
  assign in_rep = (rep_idx_q < q_cmd_i.rep_cnt);

  always_comb begin
    cur_byte = q_cmd_i.lit[lit_idx_q[1:0]];
    fin      = (lit_idx_q + 3'd1) == q_cmd_i.lit_cnt;
    if (in_rep) begin
      case (phase_q)
        PhaseFirst: cur_byte = ReplByte0;
        PhaseMid:   cur_byte = ReplByte1;
        default:    cur_byte = ReplByte2;
      endcase
      fin = ((rep_idx_q + 3'd1) == q_cmd_i.rep_cnt) && (phase_q == PhaseLast) &&
            (q_cmd_i.lit_cnt == 3'd0);
    end
  end

  always_comb begin
    rep_idx_d = rep_idx_q;
    phase_d   = phase_q;
    lit_idx_d = lit_idx_q;
    valid_d   = out_ready_i ? 1'b0 : valid_q;
    if (adv) begin
      valid_d = 1'b1;
      if (fin) begin
        rep_idx_d = 3'd0;
        phase_d   = PhaseFirst;
        lit_idx_d = 3'd0;
      end else if (in_rep) begin
        if (phase_q == PhaseLast) begin
          phase_d   = PhaseFirst;
          rep_idx_d = rep_idx_q + 3'd1;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end else begin
        lit_idx_d = lit_idx_q + 3'd1;
      end
    end
  end

  assign q_pop_o = adv && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_idx_q <= 3'd0;
      phase_q   <= PhaseFirst;
      lit_idx_q <= 3'd0;
      valid_q   <= 1'b0;
    end else begin
      rep_idx_q <= rep_idx_d;
      phase_q   <= phase_d;
      lit_idx_q <= lit_idx_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q        <= cur_byte;
      run_last_q    <= fin;
      payload_end_q <= fin && q_cmd_i.last;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign out_run_last_o    = run_last_q;
  assign out_payload_end_o = payload_end_q;

endmodule
`default_nettype wire

>>> bench/tb_utf8_sanitizer.sv
// Self-checking testbench for the streaming UTF-8 sanitizer with byte-level prediction.
`default_nettype none
module tb_utf8_sanitizer;
  import utf8s_pkg::*;

  localparam int MaxPerByte = 12;
  localparam int RandomBytes = 80;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       payload_end;
  } out_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic       m_axis_tlast_o;
  logic [0:0] m_axis_tuser_o;           // [0] run_last

  utf8_sanitizer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  logic [7:0] seq_bytes [3];
  logic [2:0] seq_len = LenBad;
  logic [1:0] seq_cnt = 2'd0;
  out_item_t  step_out [$];
  out_item_t  expected_out [$];
  int         error_cnt = 0;
  int         mismatch_cnt = 0;
  int         burst_left = 0;
  logic [7:0] rx_tick = 8'd0;
  logic [1:0] rx_mode = 2'd0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 400000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void put_byte(input logic [7:0] b);
    out_item_t it;
    if (step_out.size() < MaxPerByte) begin
      it.data = b;
      it.run_last = 1'b0;
      it.payload_end = 1'b0;
      step_out.push_back(it);
    end
  endfunction

  function automatic void put_replacement();
    put_byte(ReplByte0);
    put_byte(ReplByte1);
    put_byte(ReplByte2);
  endfunction

  function automatic void reject_held();
    for (int k = 0; k < seq_cnt; k++) begin
      put_replacement();
    end
    seq_cnt = 2'd0;
    seq_len = LenBad;
  endfunction

  function automatic void start_char(input logic [7:0] b);
    logic [2:0] len;
    len = LenBad;
    if (b < ContCode) begin
      put_byte(b);
    end else begin
      if (b >= Lead2Lo && b <= Lead2Hi) begin
        len = LenTwo;
      end else if (b >= Lead3Lo && b <= Lead3Hi) begin
        len = LenThree;
      end else if (b >= Lead4Lo && b <= Lead4Hi) begin
        len = LenFour;
      end
      if (len == LenBad) begin
        put_replacement();
      end else begin
        seq_bytes[0] = b;
        seq_cnt = 2'd1;
        seq_len = len;
      end
    end
  endfunction

  // Works out the output bytes released by one input byte and queues them.
  function automatic void sanitize_byte(input logic [7:0] b, input logic last);
    out_item_t tail;
    step_out.delete();
    if (seq_cnt != 2'd0 && seq_len > {1'b0, seq_cnt}) begin
      if ((b & ContMask) == ContCode) begin
        if ({1'b0, seq_cnt} + 3'd1 == seq_len) begin
          for (int k = 0; k < seq_cnt; k++) begin
            put_byte(seq_bytes[k]);
          end
          put_byte(b);
          seq_cnt = 2'd0;
          seq_len = LenBad;
        end else if (seq_cnt < 2'd3) begin
          seq_bytes[seq_cnt] = b;
          seq_cnt = seq_cnt + 2'd1;
        end else begin
          reject_held();
          put_replacement();
        end
      end else begin
        reject_held();
        start_char(b);
      end
    end else begin
      seq_cnt = 2'd0;
      seq_len = LenBad;
      start_char(b);
    end
    if (last && seq_cnt != 2'd0) begin
      reject_held();
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.run_last = 1'b1;
      tail.payload_end = last;
      step_out.push_back(tail);
    end
    foreach (step_out[i]) begin
      expected_out.push_back(step_out[i]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sanitize_byte(b, last);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_out.size() != 0);
  endtask

  task automatic test_ascii_bounds();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_whole_sequences();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    wait_drained();
  endtask

  task automatic test_bad_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hF5, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  // A full four-byte lead with two continuations broken by a bad byte gives
  // the most output for a single transfer.
  task automatic test_broken_sequences();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_drained();
  endtask

  task automatic test_cut_at_payload_end();
    send_byte(8'hE1, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hC2, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_payloads();
    logic [7:0] payload [$];
    logic [7:0] chr [$];
    int sent;
    int kind;
    int nb;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < RandomBytes) begin
      payload.delete();
      repeat ($urandom_range(1, 6)) begin
        chr.delete();
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          chr.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end else if (kind < 9) begin
          nb = $urandom_range(2, 4);
          case (nb)
            2: chr.push_back(8'($urandom_range(Lead2Lo, Lead2Hi)));
            3: chr.push_back(8'($urandom_range(Lead3Lo, Lead3Hi)));
            default: chr.push_back(8'($urandom_range(Lead4Lo, Lead4Hi)));
          endcase
          repeat (nb - 1) chr.push_back(8'($urandom_range(8'h80, 8'hBF)));
          if (kind == 7) begin
            chr[$urandom_range(0, nb - 1)] = 8'($urandom_range(0, 255));
          end else if (kind == 8) begin
            repeat ($urandom_range(1, nb - 1)) void'(chr.pop_back());
          end
        end else begin
          chr.push_back(8'($urandom_range(0, 255)));
        end
        foreach (chr[i]) payload.push_back(chr[i]);
      end
      foreach (payload[i]) begin
        send_byte(payload[i], i == payload.size() - 1);
        sent++;
      end
      if (!paused && sent >= RandomBytes / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  function automatic void log_mismatch(input string what, input out_item_t want,
                                       input out_item_t got);
    error_cnt++;
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit) begin
      $display("%0t: %s: expected byte %02h run_last %0b end %0b, got byte %02h run_last %0b end %0b",
               $realtime, what, want.data, want.run_last, want.payload_end,
               got.data, got.run_last, got.payload_end);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.data = m_axis_tdata_o;
      got.run_last = m_axis_tuser_o[0];
      got.payload_end = m_axis_tlast_o;
      if (expected_out.size() == 0) begin
        want = '0;
        log_mismatch("unexpected transfer", want, got);
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          log_mismatch("mismatch", want, got);
        end
      end
    end
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) begin
      rx_mode <= 2'($urandom_range(0, 3));
    end
    case (rx_mode)
      2'd0: m_axis_tready_i <= 1'b1;
      2'd1: m_axis_tready_i <= ($urandom_range(0, 2) != 0);
      2'd2: m_axis_tready_i <= (rx_tick[2:0] != 3'd5);
      default: m_axis_tready_i <= (rx_tick[3:1] == 3'd0);
    endcase
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_bounds();
    test_whole_sequences();
    test_bad_leads();
    test_broken_sequences();
    test_cut_at_payload_end();
    test_random_payloads();
    repeat (40) @(posedge clk_i);
    if (error_cnt == 0 && expected_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
